// ===== src/assert_macros.svh =====
// assertion macros shared by the hash core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while out of reset
`define SHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define SHA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sha256_pkg.sv =====
// shared types, constants and round functions of the sha-256 hash core
`timescale 1ns / 1ps

package sha256_pkg;

	localparam logic [5:0] MSG_MAX_BYTES = 6'd55;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [2:0] LAST_WORD     = 3'd7;
	localparam logic [7:0] PAD_BYTE      = 8'h80;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_DIGEST,
		ST_EMIT
	} ctrl_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic       load;
		logic       pad;
		logic       round;
		logic       finish;
		logic       emit;
		logic       last_word;
		logic [5:0] round_idx;
		logic [2:0] word_idx;
	} dp_cmd_t;

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ===== src/sha256_ctrl.sv =====
// controller state machine of the sha-256 hash core
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha256_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                end_of_message,
	output logic                busy,
	output sha256_pkg::dp_cmd_t cmd
);
	import sha256_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [5:0]  cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.pad = 1'b1;
				cnt_d   = '0;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round     = 1'b1;
				cmd.round_idx = cnt_q;
				cnt_d         = cnt_q + 6'd1;
				if (cnt_q == LAST_ROUND) begin
					state_d = ST_DIGEST;
				end
			end
			ST_DIGEST: begin
				cmd.finish = 1'b1;
				cnt_d      = '0;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit      = 1'b1;
				cmd.word_idx  = cnt_q[2:0];
				cmd.last_word = (cnt_q[2:0] == LAST_WORD);
				cnt_d         = cnt_q + 6'd1;
				if (cnt_q[2:0] == LAST_WORD) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	`SHA_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.pad, cmd.round, cmd.finish, cmd.emit}), "more than one datapath command")
	`SHA_ASSERT(a_rounds_end, (state_q == ST_ROUND && cnt_q == LAST_ROUND) |=> (state_q == ST_DIGEST), "compression did not end after the last round")
	`SHA_ASSERT(a_busy_fall, $fell(busy) |-> $past(cmd.emit && cmd.last_word), "busy dropped before the last digest word")

endmodule

// ===== src/sha256_dp.sv =====
// datapath of the sha-256 hash core: message block, schedule, rounds and digest
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha256_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic                carries_byte,
	input  sha256_pkg::dp_cmd_t cmd,
	output logic                word_valid,
	output logic [31:0]         digest_word,
	output logic [2:0]          word_number,
	output logic                final_word,
	output logic                too_long
);
	import sha256_pkg::*;

	// message block, reused as the sliding schedule window during the rounds
	logic [31:0] msg_q [16];
	logic [5:0]  cnt_q;
	logic        ovf_q;
	logic [31:0] var_q [8];
	logic [31:0] dig_q [8];

	logic        valid_q;
	logic [31:0] word_q;
	logic [2:0]  num_q;
	logic        fin_q;
	logic        long_q;

	logic [3:0]  wr_idx;
	logic [4:0]  byte_shift;
	logic [7:0]  ins_byte;
	logic [31:0] ins_word;
	logic        store_ok;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	assign wr_idx     = cnt_q[5:2];
	assign byte_shift = {~cnt_q[1:0], 3'b000};
	assign ins_byte   = cmd.pad ? PAD_BYTE : data_byte;
	assign ins_word   = {24'd0, ins_byte} << byte_shift;
	assign store_ok   = (cnt_q < MSG_MAX_BYTES);

	assign w_new = small_sigma1(msg_q[14]) + msg_q[9] + small_sigma0(msg_q[1]) + msg_q[0];
	assign ch    = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign maj   = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign t1    = var_q[7] + big_sigma1(var_q[4]) + ch + ROUND_K[cmd.round_idx] + msg_q[0];
	assign t2    = big_sigma0(var_q[0]) + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_q <= '{default: '0};
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.load && carries_byte) begin
				if (store_ok) begin
					msg_q[wr_idx] <= msg_q[wr_idx] | ins_word;
					cnt_q         <= cnt_q + 6'd1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.pad) begin
				msg_q[wr_idx] <= msg_q[wr_idx] | ins_word;
				msg_q[15]     <= {23'd0, cnt_q, 3'b000};
			end
			if (cmd.round) begin
				for (int i = 0; i < 15; i++) begin
					msg_q[i] <= msg_q[i + 1];
				end
				msg_q[15] <= w_new;
			end
			if (cmd.finish) begin
				msg_q <= '{default: '0};
				cnt_q <= '0;
			end
			if (cmd.emit && cmd.last_word) begin
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pad) begin
			var_q <= INIT_HASH;
		end
		if (cmd.round) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
		if (cmd.finish) begin
			for (int i = 0; i < 8; i++) begin
				dig_q[i] <= INIT_HASH[i] + var_q[i];
			end
		end
		if (cmd.emit) begin
			for (int i = 0; i < 7; i++) begin
				dig_q[i] <= dig_q[i + 1];
			end
			word_q <= dig_q[0];
			num_q  <= cmd.word_idx;
			fin_q  <= cmd.last_word;
			long_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	assign word_valid  = valid_q;
	assign digest_word = word_q;
	assign word_number = num_q;
	assign final_word  = fin_q;
	assign too_long    = long_q;

	`SHA_ASSERT(a_clear_after, cmd.finish |=> (cnt_q == '0 && msg_q[15] == '0), "block not cleared after compression")
	`SHA_ASSERT(a_first_word, $rose(valid_q) |-> (num_q == '0), "digest did not start at word zero")
	`SHA_ASSERT(a_count_cap, cnt_q <= MSG_MAX_BYTES, "byte count passed the single-block limit")

endmodule

// ===== src/sha256_single_block_hash_core.sv =====
// sha-256 of a single-block message: one byte word per start, eight digest words out
// a word without end_of_message is taken while busy stays low, one per cycle
// after the final word is taken busy is high through pad, 64 rounds, digest add and emit
// digest words appear after the digest add, one per cycle, no stall
// a new message is taken only after the last emit step; the rounds run one per cycle
// reset clears the block, byte count, overflow flag and control; no clearing pass
`timescale 1ns / 1ps

module sha256_single_block_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  data_byte,
	input  logic        carries_byte,
	input  logic        end_of_message,
	output logic        word_valid,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word,
	output logic        too_long
);
	import sha256_pkg::*;

	// command bundle from the sequencer to the datapath
	dp_cmd_t cmd;

	// sequencer: load, pad, 64 rounds, digest add, eight output words
	sha256_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.end_of_message (end_of_message),
		.busy           (busy),
		.cmd            (cmd)
	);

	// datapath: byte packing, padding, schedule window, round logic, digest register
	sha256_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.carries_byte (carries_byte),
		.cmd          (cmd),
		.word_valid   (word_valid),
		.digest_word  (digest_word),
		.word_number  (word_number),
		.final_word   (final_word),
		.too_long     (too_long)
	);

endmodule

// ===== sim/tb.sv =====
// self-checking testbench of the single-block sha-256 hash core
`timescale 1ns / 1ps

module tb;

	// message bytes that fit in one block once the marker byte and length are added
	localparam int MAX_BYTES = 55;
	localparam int ITEM_TARGET = 410;
	// pause from the last digest word to the end of the run
	localparam int DRAIN_CYCLES = 80;

	// sha-256 round constants
	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// standard initial hash value
	localparam logic [31:0] SHA_H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_MARKER = 8'h80;

	// one digest word as it should leave the block
	typedef struct packed {
		logic [31:0] word_val;
		logic [2:0]  index;
		logic        last;
		logic        overlong;
	} digest_word_t;

	// message builder, sha-256 predictor and digest word checker
	class digest_scoreboard;
		logic [31:0]  msg_words [16];
		int unsigned  msg_len;
		bit           dropped;
		logic [31:0]  hash_out [8];
		digest_word_t expected_digest_words [$];
		int unsigned  errors;
		int unsigned  items;
		int unsigned  messages;
		int unsigned  overlong_msgs;
		int unsigned  empty_msgs;
		int unsigned  words_checked;

		function void clear_message();
			foreach (msg_words[i])
				msg_words[i] = '0;
			msg_len = 0;
			dropped = 1'b0;
		endfunction

		function logic [31:0] ror(input logic [31:0] x, input int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		// 64 rounds over the current message block, result in hash_out
		function void sha256_compress();
			logic [31:0] w [16];
			logic [31:0] v [8];
			logic [31:0] wt, s0, s1, t1, t2;
			w = msg_words;
			v = SHA_H0;
			for (int t = 0; t < 64; t++) begin
				if (t < 16) begin
					wt = w[t];
				end else begin
					s1 = ror(w[(t - 2) % 16], 17) ^ ror(w[(t - 2) % 16], 19)
						^ (w[(t - 2) % 16] >> 10);
					s0 = ror(w[(t - 15) % 16], 7) ^ ror(w[(t - 15) % 16], 18)
						^ (w[(t - 15) % 16] >> 3);
					wt = s1 + w[(t - 7) % 16] + s0 + w[t % 16];
					w[t % 16] = wt;
				end
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + wt;
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				hash_out[i] = SHA_H0[i] + v[i];
		endfunction

		// called for every accepted word
		function void note_item(input logic [7:0] d, input logic c, input logic e);
			digest_word_t dw;
			if (c || e)
				items++;
			if (c) begin
				if (msg_len < MAX_BYTES) begin
					msg_words[msg_len / 4] |= 32'(d) << (24 - 8 * (msg_len % 4));
					msg_len++;
				end else begin
					dropped = 1'b1;
				end
			end
			if (!e)
				return;
			msg_words[msg_len / 4] |= 32'(PAD_MARKER) << (24 - 8 * (msg_len % 4));
			msg_words[14] = '0;
			msg_words[15] = 32'(msg_len * 8);
			sha256_compress();
			for (int i = 0; i < 8; i++) begin
				dw.word_val = hash_out[i];
				dw.index = 3'(i);
				dw.last = (i == 7);
				dw.overlong = dropped;
				expected_digest_words.push_back(dw);
			end
			messages++;
			if (dropped)
				overlong_msgs++;
			if (msg_len == 0)
				empty_msgs++;
			clear_message();
		endfunction

		task report(input string what);
			errors++;
			if (errors <= 40)
				$display("%0t tb: error: %s", $time, what);
		endtask

		task check_word(input logic [31:0] dg, input logic [2:0] nr, input logic fw,
				input logic tl);
			digest_word_t want;
			if (expected_digest_words.size() == 0) begin
				report($sformatf("digest word %h (number %0d) with none expected", dg, nr));
				return;
			end
			want = expected_digest_words.pop_front();
			words_checked++;
			if (dg !== want.word_val)
				report($sformatf("digest word %0d: got %h, want %h", want.index, dg,
					want.word_val));
			if (nr !== want.index)
				report($sformatf("word number: got %0d, want %0d", nr, want.index));
			if (fw !== want.last)
				report($sformatf("final word flag on word %0d: got %b, want %b",
					want.index, fw, want.last));
			if (tl !== want.overlong)
				report($sformatf("too long flag on word %0d: got %b, want %b",
					want.index, tl, want.overlong));
		endtask

		function int pending();
			return expected_digest_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        carries_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        busy;
	logic        word_valid;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        final_word;
	logic        too_long;

	digest_scoreboard sb = new;

	sha256_single_block_hash_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.data_byte      (data_byte),
		.carries_byte   (carries_byte),
		.end_of_message (end_of_message),
		.word_valid     (word_valid),
		.digest_word    (digest_word),
		.word_number    (word_number),
		.final_word     (final_word),
		.too_long       (too_long)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// digest words are sampled at the edge that ends their strobe cycle
	always @(posedge clk) begin
		if (arst_n && word_valid === 1'b1)
			sb.check_word(digest_word, word_number, final_word, too_long);
	end

	// present one word and hold it until the block takes it; start stays high
	// afterwards so back-to-back words never see a low pulse
	task automatic send_item(input logic [7:0] d, input logic c, input logic e);
		start <= 1'b1;
		data_byte <= d;
		carries_byte <= c;
		end_of_message <= e;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_item(d, c, e);
	endtask

	// sender pause: mostly none or short, now and then long enough to span
	// a large part of the compression
	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 60)
			n = 0;
		else if (r < 93)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 90);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every digest word owed has come out
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// one message of random bytes; the end mark rides on the last byte or on
	// a word of its own; a few words that neither carry a byte nor end the
	// message are slipped in as noise
	task automatic send_message(input int n_bytes, input bit mark_on_byte, input bit burst);
		for (int k = 0; k < n_bytes; k++) begin
			if (!burst)
				idle_gap();
			if (!burst && $urandom_range(0, 19) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, mark_on_byte && (k == n_bytes - 1));
		end
		if (!mark_on_byte || n_bytes == 0) begin
			if (!burst)
				idle_gap();
			send_item(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	initial begin
		int r;
		int len;
		int msg_nr;
		sb.clear_message();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message
		send_item(8'h00, 1'b0, 1'b1);
		// "abc", end mark on the last byte
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// all-ones byte, then an end word that carries nothing
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// single zero byte on the end word
		send_item(8'h00, 1'b1, 1'b1);
		// ignored bytes around a real one; stale data on the end word
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b0);
		send_item(8'h3c, 1'b0, 1'b1);
		// empty message whose unused data byte is all ones
		send_item(8'hff, 1'b0, 1'b1);
		wait_drained();

		// random messages: many near or over the one-block limit
		msg_nr = 0;
		while (sb.items < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				len = 0;
			else if (r < 18)
				len = MAX_BYTES;
			else if (r < 30)
				len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 15);
			else if (r < 36)
				len = MAX_BYTES - 1;
			else if (r < 60)
				len = $urandom_range(1, 8);
			else
				len = $urandom_range(1, MAX_BYTES - 2);
			send_message(len, $urandom_range(0, 1), $urandom_range(0, 9) < 3);
			msg_nr++;
			if (msg_nr % 7 == 3)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d digest words never came out", sb.pending()));

		$display("tb: %0d words sent, %0d messages hashed (%0d empty, %0d over the limit)",
			sb.items, sb.messages, sb.empty_msgs, sb.overlong_msgs);
		$display("tb: %0d digest words checked, %0d mismatches", sb.words_checked,
			sb.errors);
		if (sb.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#10ms;
		$display("tb: timeout with %0d digest words outstanding", sb.pending());
		$display("tb: FAIL");
		$finish;
	end

endmodule
